// ===== rtl/core/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg: shared definitions of the table linear interpolator
// Kind and range codes, default sizes, datapath widths and the command
// word of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

  // default sizes handed down from the top level
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths of the ports
  localparam int FIELD_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  // product / dividend width of the shared unit (product wraps here)
  localparam int PROD_W = 64;

  // input word kinds
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INVERSE = 2'd2;

  // range status codes
  localparam logic [STAT_W-1:0] RANGE_INSIDE = 2'd0;
  localparam logic [STAT_W-1:0] RANGE_BELOW  = 2'd1;
  localparam logic [STAT_W-1:0] RANGE_ABOVE  = 2'd2;

  // command to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic op_div;   // 0 multiply, 1 divide
  } tli_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise linear breakpoint table lookup
// Holds a table of (x, y) breakpoints and answers forward (x to y) and
// inverse (y to x) queries by binary search and linear interpolation.
// ----------------------------------------------------------------------------
// One word is worked on at a time; in_tready is high only while the
// sequencer is idle. A write subtracts TABLE_DEPTH from entry_index until
// it is below the depth, which happens only when the depth is below 256,
// then writes the entry. A query below the first key or at or above the
// last key takes that end's value without a search. An interpolated query
// runs a binary search over the live entries on the registered table read,
// then a shift-add multiply and a restoring division on the one shared
// adder. A finished result waits in the output register while the next
// word is taken. Kind 3 is dropped without a result. The table is not
// cleared by reset; entries must be written before they are searched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration: entry_count
  input  wire logic         cfg_wr_en,
  input  wire logic [8:0]   cfg_wr_data,
  // input words
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] entry_index, [39:8] entry_x, [71:40] entry_y, [103:72] query_value
  input  wire logic [103:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]   in_tuser,
  // result words
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] result_value
  output logic      [31:0]  out_tdata,
  // [1:0] range_status
  output logic      [1:0]   out_tuser
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int SW = (VW + 2 > 34) ? VW + 2 : 34;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(32'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(32'sh8000_0000);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WMOD = 4'd1;
  localparam logic [3:0] S_K0   = 4'd2;
  localparam logic [3:0] S_KH   = 4'd3;
  localparam logic [3:0] S_SRCH = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_LO   = 4'd6;
  localparam logic [3:0] S_HI   = 4'd7;
  localparam logic [3:0] S_MULS = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_CLMP = 4'd11;
  localparam logic [3:0] S_ADD  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // field to stored value: low VW bits, zero-extended when VW is wider
  function automatic logic signed [VW-1:0] to_val(input logic [FIELD_W-1:0] f);
    logic [2*FIELD_W+VW-1:0] z;
    z = {{(FIELD_W+VW){1'b0}}, f};
    return z[VW-1:0];
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > SAT_MAX) c = SAT_MAX;
    if (v < SAT_MIN) c = SAT_MIN;
    return c[31:0];
  endfunction

  // input field split
  logic [KIND_W-1:0]  in_kind;
  logic [INDEX_W-1:0] in_index;
  logic [FIELD_W-1:0] in_x;
  logic [FIELD_W-1:0] in_y;
  logic [FIELD_W-1:0] in_q;

  assign in_kind  = in_tuser;
  assign in_index = in_tdata[7:0];
  assign in_x     = in_tdata[39:8];
  assign in_y     = in_tdata[71:40];
  assign in_q     = in_tdata[103:72];

  // registers
  logic [3:0]              state_r, state_nxt;
  logic [COUNT_W-1:0]      count_r;
  logic                    inv_r;
  logic [INDEX_W-1:0]      idx_r;
  logic signed [VW-1:0]    wx_r, wy_r, q_r;
  logic [AW-1:0]           lo_r, hi_r, mid_r;
  logic signed [VW-1:0]    k1_r, v1_r;
  logic                    neg_r;
  logic [VW:0]             mag_r, span_r, off_r, qc_r;
  logic signed [SW-1:0]    res_val_r;
  logic [STAT_W-1:0]       res_stat_r;
  logic                    out_valid_r;
  logic [31:0]             out_value_r;
  logic [STAT_W-1:0]       out_stat_r;

  // table and shared unit wiring
  logic                    tbl_wr_en;
  logic [AW-1:0]           tbl_rd_addr;
  logic [VW-1:0]           tbl_rd_x, tbl_rd_y;
  tli_cmd_t                md_cmd;
  logic [PROD_W-1:0]       md_opa, md_opb, md_result;
  logic                    md_done;

  // combinational helpers
  logic                    in_acc;
  logic                    out_load;
  logic                    idx_ge;
  logic [CW-1:0]           cnt_ext, live_n;
  logic signed [VW-1:0]    key, val;
  logic [AW-1:0]           span_idx;
  logic [AW:0]             mid_sum;
  logic [AW-1:0]           mid_c;
  logic                    more_steps;
  logic signed [VW:0]      dv_c, span_c, off_c;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // write index modulo depth, one subtraction a cycle
  assign idx_ge    = (CW'(idx_r) >= CW'(TABLE_DEPTH));
  assign tbl_wr_en = (state_r == S_WMOD) && !idx_ge;

  // live entry count clamped to [2, TABLE_DEPTH]
  assign cnt_ext = CW'(count_r);
  always_comb begin
    live_n = cnt_ext;
    if (cnt_ext < CW'(2)) live_n = CW'(2);
    if (cnt_ext > CW'(TABLE_DEPTH)) live_n = CW'(TABLE_DEPTH);
  end

  // key column and value column by query direction
  assign key = inv_r ? tbl_rd_y : tbl_rd_x;
  assign val = inv_r ? tbl_rd_x : tbl_rd_y;

  // search step
  assign span_idx   = hi_r - lo_r;
  assign more_steps = (span_idx > AW'(1));
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c      = mid_sum[AW:1];

  // interpolation operands from the bracketing pair
  assign dv_c   = {val[VW-1], val} - {v1_r[VW-1], v1_r};
  assign span_c = {key[VW-1], key} - {k1_r[VW-1], k1_r};
  assign off_c  = {q_r[VW-1], q_r} - {k1_r[VW-1], k1_r};

  // table read address
  always_comb begin
    case (state_r)
      S_K0:    tbl_rd_addr = hi_r;
      S_SRCH:  tbl_rd_addr = more_steps ? mid_c : lo_r;
      S_LO:    tbl_rd_addr = hi_r;
      default: tbl_rd_addr = '0;
    endcase
  end

  // shared unit commands
  always_comb begin
    md_cmd = '0;
    md_opa = '0;
    md_opb = '0;
    case (state_r)
      S_MULS: begin
        md_cmd.start = 1'b1;
        md_opa       = PROD_W'(mag_r);
        md_opb       = PROD_W'(off_r);
      end
      S_MUL: begin
        md_cmd.start  = md_done;
        md_cmd.op_div = 1'b1;
        md_opa        = md_result;
        md_opb        = PROD_W'(span_r);
      end
      default: begin
        md_cmd = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_WRITE:   state_nxt = S_WMOD;
            KIND_FORWARD: state_nxt = S_K0;
            KIND_INVERSE: state_nxt = S_K0;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_WMOD: if (!idx_ge) state_nxt = S_IDLE;
      S_K0:   state_nxt = (q_r < key) ? S_DONE : S_KH;
      S_KH:   state_nxt = (q_r >= key) ? S_DONE : S_SRCH;
      S_SRCH: state_nxt = more_steps ? S_CMP : S_LO;
      S_CMP:  state_nxt = S_SRCH;
      S_LO:   state_nxt = S_HI;
      S_HI:   state_nxt = S_MULS;
      S_MULS: state_nxt = S_MUL;
      S_MUL:  if (md_done) state_nxt = S_DIV;
      S_DIV:  if (md_done) state_nxt = S_CLMP;
      S_CLMP: state_nxt = S_ADD;
      S_ADD:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= COUNT_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          inv_r <= (in_kind == KIND_INVERSE);
          idx_r <= in_index;
          wx_r  <= to_val(in_x);
          wy_r  <= to_val(in_y);
          q_r   <= to_val(in_q);
          hi_r  <= AW'(live_n - CW'(1));
          lo_r  <= '0;
        end
      end
      S_WMOD: begin
        if (idx_ge) begin
          idx_r <= idx_r - INDEX_W'(TABLE_DEPTH);
        end
      end
      // below the first key
      S_K0: begin
        res_val_r  <= SW'(val);
        res_stat_r <= RANGE_BELOW;
      end
      // above or at the last key
      S_KH: begin
        res_val_r  <= SW'(val);
        res_stat_r <= (q_r > key) ? RANGE_ABOVE : RANGE_INSIDE;
      end
      S_SRCH: mid_r <= mid_c;
      S_CMP: begin
        if (key <= q_r) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r;
        end
      end
      S_LO: begin
        k1_r <= key;
        v1_r <= val;
      end
      S_HI: begin
        neg_r  <= dv_c[VW];
        mag_r  <= dv_c[VW] ? (VW+1)'(-dv_c) : dv_c;
        span_r <= span_c;
        off_r  <= off_c;
      end
      // quotient limited to |dv|
      S_CLMP: qc_r <= (md_result > PROD_W'(mag_r)) ? mag_r : md_result[VW:0];
      S_ADD: begin
        res_stat_r <= RANGE_INSIDE;
        if (neg_r) begin
          res_val_r <= SW'(v1_r) - $signed({{(SW-VW-1){1'b0}}, qc_r});
        end else begin
          res_val_r <= SW'(v1_r) + $signed({{(SW-VW-1){1'b0}}, qc_r});
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_value_r <= sat32(res_val_r);
      out_stat_r  <= res_stat_r;
    end
  end

  tli_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (AW'(idx_r)),
    .wr_x    (wx_r),
    .wr_y    (wy_r),
    .rd_addr (tbl_rd_addr),
    .rd_x    (tbl_rd_x),
    .rd_y    (tbl_rd_y)
  );

  tli_muldiv #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (md_cmd),
    .opa    (md_opa),
    .opb    (md_opb),
    .done   (md_done),
    .result (md_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_stat_r;

endmodule

`default_nettype wire

// ===== rtl/core/tli_table.sv =====
// ----------------------------------------------------------------------------
// tli_table: breakpoint storage
// Two single-port-write, single-port-read memories for the x and y columns,
// read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tli_table
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [VALUE_WIDTH-1:0] wr_x,
  input  wire logic [VALUE_WIDTH-1:0] wr_y,
  input  wire logic [AW-1:0]          rd_addr,
  output logic      [VALUE_WIDTH-1:0] rd_x,
  output logic      [VALUE_WIDTH-1:0] rd_y
);

  logic [VALUE_WIDTH-1:0] mem_x [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] mem_y [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tli_muldiv.sv =====
// ----------------------------------------------------------------------------
// tli_muldiv: shared shift-add multiplier and restoring divider
// One adder serves both operations, one bit per cycle. Multiply runs
// VALUE_WIDTH+1 steps, divide runs PROD_W steps; done pulses in the cycle
// after the last step and the result holds until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tli_muldiv
  import tli_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tli_cmd_t          cmd,
  input  wire logic [PROD_W-1:0] opa,     // multiplicand or dividend
  input  wire logic [PROD_W-1:0] opb,     // multiplier or divisor
  output logic                   done,
  output logic      [PROD_W-1:0] result   // product or quotient
);

  localparam int CNTW      = $clog2(PROD_W + 1);
  localparam int MUL_STEPS = VALUE_WIDTH + 1;
  localparam int DIV_STEPS = PROD_W;

  logic            busy_r;
  logic            div_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [PROD_W-1:0] acc_r;   // product accumulator / remainder
  logic [PROD_W-1:0] x_r;     // shifted multiplicand / dividend-quotient
  logic [PROD_W-1:0] y_r;     // multiplier bits / divisor

  logic [PROD_W-1:0] rem_sh;
  logic [PROD_W-1:0] add_a;
  logic [PROD_W-1:0] add_b;
  logic [PROD_W:0]   sum;
  logic              carry;
  logic              last;

  // shared adder: acc + x for multiply, shifted remainder - divisor for divide
  assign rem_sh = {acc_r[PROD_W-2:0], x_r[PROD_W-1]};
  assign add_a  = div_r ? rem_sh : acc_r;
  assign add_b  = div_r ? ~y_r : x_r;
  assign sum    = {1'b0, add_a} + {1'b0, add_b} + (PROD_W+1)'(div_r);
  assign carry  = sum[PROD_W];
  assign last   = (cnt_r == CNTW'(1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (cmd.start) begin
        busy_r <= 1'b1;
        div_r  <= cmd.op_div;
        cnt_r  <= cmd.op_div ? CNTW'(DIV_STEPS) : CNTW'(MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      x_r   <= opa;
      y_r   <= opb;
    end else if (busy_r) begin
      if (div_r) begin
        acc_r <= carry ? sum[PROD_W-1:0] : rem_sh;
        x_r   <= {x_r[PROD_W-2:0], carry};
      end else begin
        if (y_r[0]) begin
          acc_r <= sum[PROD_W-1:0];
        end
        x_r <= {x_r[PROD_W-2:0], 1'b0};
        y_r <= {1'b0, y_r[PROD_W-1:1]};
      end
    end
  end

  assign done   = done_r;
  assign result = div_r ? x_r : acc_r;

endmodule

`default_nettype wire
